// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers for the rtl sequencer, empty when building for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// plain property checked at every clock
`define VDI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// consequent checked in the clock after the antecedent
`define VDI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define VDI_ASSERT(lbl, clk, rstn, prop, msg)
`define VDI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/vdi_pkg.sv =====
// ----------------------------------------------------------------------------
// vdi_pkg
// types, constants and float helpers for the vertex dedup indexer
// ----------------------------------------------------------------------------
package vdi_pkg;

  localparam int unsigned KEY_WORDS = 8;
  localparam int unsigned OUT_IDX_W = 10;
  localparam int unsigned EPOCH_W   = 4;

  localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
  localparam logic [31:0] FNV_PRIME = 32'h0100_0193;
  localparam logic [31:0] ONE_F     = 32'h3F80_0000;
  localparam logic [31:0] ZERO_F    = 32'h0000_0000;

  typedef struct packed {
    logic        first_of_mesh;
    logic [31:0] position_x;
    logic [31:0] position_y;
    logic [31:0] position_z;
    logic        has_normal;
    logic [31:0] normal_x;
    logic [31:0] normal_y;
    logic [31:0] normal_z;
    logic        has_texcoord;
    logic [31:0] tex_u;
    logic [31:0] tex_v;
  } in_item_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] vtx_idx;
    logic                 is_new;
    logic                 overflow;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic clear_mesh;
    logic sweep_start;
    logic sweep_wr;
    logic hash_init;
    logic hash_step;
    logic mod_step;
    logic probe_start;
    logic slot_rd;
    logic ent_rd;
    logic probe_next;
    logic insert;
    logic res_match;
    logic res_new;
    logic res_ovf;
  } dp_cmd_t;

  typedef struct packed {
    logic first;
    logic epoch_wrap;
    logic sweep_last;
    logic step_last;
    logic mod_last;
    logic slot_occ;
    logic key_match;
    logic probe_last;
    logic table_full;
  } dp_sts_t;

  function automatic logic is_nan32(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  // float equality: signed zeros equal, nan never equal
  function automatic logic feq(input logic [31:0] a, input logic [31:0] b);
    logic zeros;
    zeros = ((a[30:0] | b[30:0]) == 31'd0);
    return !is_nan32(a) && !is_nan32(b) && (zeros || (a == b));
  endfunction

  function automatic logic [31:0] zero_norm(input logic [31:0] w);
    return (w[30:0] == 31'd0) ? ZERO_F : w;
  endfunction

endpackage

// ===== hw/rtl/vdi_datapath.sv =====
// ----------------------------------------------------------------------------
// vdi_datapath
// key register, hash and modulo units, slot table, vertex store, result word
// ----------------------------------------------------------------------------
module vdi_datapath #(
  parameter int unsigned MAX_VERTICES = 1024,
  parameter int unsigned HASH_SLOTS   = 2048
) (
  input  logic               clk,
  input  logic               rst_n,
  input  vdi_pkg::dp_cmd_t   cmd,
  input  vdi_pkg::in_item_t  in_data,
  output vdi_pkg::dp_sts_t   sts,
  output vdi_pkg::out_item_t out_data
);
  import vdi_pkg::*;

  localparam int unsigned VW  = $clog2(MAX_VERTICES);
  localparam int unsigned CW  = VW + 1;
  localparam int unsigned SW  = $clog2(HASH_SLOTS);
  localparam int unsigned SEW = 1 + EPOCH_W + VW;

  // floor(2^32 / slots): quotient estimate is exact or one short
  localparam logic [31:0] RECIP   = 32'(64'h1_0000_0000 / 64'(HASH_SLOTS));
  localparam logic [31:0] SLOTS32 = 32'(HASH_SLOTS);

  logic [KEY_WORDS-1:0][31:0] key_r;
  logic                       first_r;
  logic [31:0]                h_r, h_nxt;
  logic [31:0]                q_r;
  logic [31:0]                r_r;
  logic [SW-1:0]              rem_r;
  logic [2:0]                 step_r;
  logic [SW-1:0]              slot_r, slot_inc;
  logic [SW-1:0]              probe_r;
  logic [CW-1:0]              count_r;
  logic [EPOCH_W-1:0]         epoch_r;
  logic [SEW-1:0]             slot_rd_r;
  logic [KEY_WORDS-1:0][31:0] ent_rd_r;
  out_item_t                  out_r;

  logic [SEW-1:0]             slot_mem [HASH_SLOTS];
  logic [KEY_WORDS-1:0][31:0] vert_mem [MAX_VERTICES];

  logic [VW-1:0]              slot_idx;
  logic [VW-1:0]              sel_idx;
  logic [VW+OUT_IDX_W-1:0]    wide_idx;
  logic [31:0]                mix, prod;
  logic [63:0]                qprod;
  logic [31:0]                qn;
  logic [31:0]                r_fold;
  logic                       match_all;

  // one fnv-style round per cycle
  always_comb begin
    mix   = h_r ^ zero_norm(key_r[step_r]);
    prod  = mix * FNV_PRIME;
    h_nxt = prod ^ (prod >> 15);
  end

  // remainder by reciprocal: quotient, back-multiply, one fold
  always_comb begin
    qprod  = {32'd0, h_r} * {32'd0, RECIP};
    qn     = q_r * SLOTS32;
    r_fold = (r_r >= SLOTS32) ? r_r - SLOTS32 : r_r;
  end

  assign slot_inc = (slot_r == SW'(HASH_SLOTS - 1)) ? '0 : slot_r + 1'b1;
  assign slot_idx = slot_rd_r[VW-1:0];

  always_comb begin
    match_all = 1'b1;
    for (int i = 0; i < KEY_WORDS; i++) begin
      if (!feq(ent_rd_r[i], key_r[i])) match_all = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      first_r  <= in_data.first_of_mesh;
      key_r[0] <= in_data.position_x;
      key_r[1] <= in_data.position_y;
      key_r[2] <= in_data.position_z;
      key_r[3] <= in_data.has_normal   ? in_data.normal_x : ZERO_F;
      key_r[4] <= in_data.has_normal   ? in_data.normal_y : ZERO_F;
      key_r[5] <= in_data.has_normal   ? in_data.normal_z : ONE_F;
      key_r[6] <= in_data.has_texcoord ? in_data.tex_u    : ZERO_F;
      key_r[7] <= in_data.has_texcoord ? in_data.tex_v    : ZERO_F;
    end
    if (cmd.hash_init) begin
      h_r    <= FNV_BASIS;
      step_r <= '0;
    end else if (cmd.hash_step) begin
      h_r    <= h_nxt;
      step_r <= step_r + 1'b1;
    end else if (cmd.mod_step) begin
      step_r <= step_r + 1'b1;
      case (step_r)
        3'd0: q_r <= qprod[63:32];
        3'd1: r_r <= h_r - qn;
        default: rem_r <= r_fold[SW-1:0];
      endcase
    end
    if (cmd.probe_start) probe_r <= '0;
    else if (cmd.probe_next) probe_r <= probe_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= '0;
      count_r <= '0;
      epoch_r <= '0;
    end else begin
      if (cmd.sweep_start) slot_r <= '0;
      else if (cmd.probe_start) slot_r <= rem_r;
      else if (cmd.sweep_wr || cmd.probe_next) slot_r <= slot_inc;
      if (cmd.clear_mesh) begin
        count_r <= '0;
        epoch_r <= epoch_r + 1'b1;
      end else if (cmd.insert) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  // slot table: tag = occupied, epoch, vertex index
  always_ff @(posedge clk) begin
    if (cmd.sweep_wr || cmd.insert) begin
      slot_mem[slot_r] <= cmd.insert ? {1'b1, epoch_r, count_r[VW-1:0]} : '0;
    end
    if (cmd.slot_rd) slot_rd_r <= slot_mem[slot_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) vert_mem[count_r[VW-1:0]] <= key_r;
    if (cmd.ent_rd) ent_rd_r <= vert_mem[slot_idx];
  end

  assign sel_idx  = cmd.res_match ? slot_idx : (cmd.res_new ? count_r[VW-1:0] : '0);
  assign wide_idx = {{OUT_IDX_W{1'b0}}, sel_idx};

  always_ff @(posedge clk) begin
    if (cmd.res_match || cmd.res_new || cmd.res_ovf) begin
      out_r.vtx_idx  <= wide_idx[OUT_IDX_W-1:0];
      out_r.is_new   <= cmd.res_new;
      out_r.overflow <= cmd.res_ovf;
    end
  end

  assign out_data = out_r;

  always_comb begin
    sts            = '0;
    sts.first      = first_r;
    sts.epoch_wrap = &epoch_r;
    sts.sweep_last = (slot_r == SW'(HASH_SLOTS - 1));
    sts.step_last  = (step_r == 3'd7);
    sts.mod_last   = (step_r == 3'd2);
    sts.slot_occ   = slot_rd_r[SEW-1] && (slot_rd_r[SEW-2:VW] == epoch_r);
    sts.key_match  = match_all;
    sts.probe_last = (probe_r == SW'(HASH_SLOTS - 1));
    sts.table_full = (count_r >= CW'(MAX_VERTICES));
  end

endmodule

// ===== hw/rtl/vdi_ctrl.sv =====
// ----------------------------------------------------------------------------
// vdi_ctrl
// sequencer: clear sweep, hash, modulo, probe loop, insert and result handoff
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vdi_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  vdi_pkg::dp_sts_t sts,
  output vdi_pkg::dp_cmd_t cmd
);
  import vdi_pkg::*;

  localparam logic [3:0] S_SWEEP_RST  = 4'd0;
  localparam logic [3:0] S_IDLE       = 4'd1;
  localparam logic [3:0] S_START      = 4'd2;
  localparam logic [3:0] S_SWEEP_ITEM = 4'd3;
  localparam logic [3:0] S_HASH       = 4'd4;
  localparam logic [3:0] S_MOD        = 4'd5;
  localparam logic [3:0] S_PSTART     = 4'd6;
  localparam logic [3:0] S_SLOT_RD    = 4'd7;
  localparam logic [3:0] S_SLOT_CHK   = 4'd8;
  localparam logic [3:0] S_ENT_CHK    = 4'd9;
  localparam logic [3:0] S_INSERT     = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       res_any;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_SWEEP_RST: begin
        cmd.sweep_wr = 1'b1;
        if (sts.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        cmd.hash_init = 1'b1;
        state_nxt     = S_HASH;
        if (sts.first) begin
          cmd.clear_mesh = 1'b1;
          if (sts.epoch_wrap) begin
            cmd.sweep_start = 1'b1;
            state_nxt       = S_SWEEP_ITEM;
          end
        end
      end
      S_SWEEP_ITEM: begin
        cmd.sweep_wr = 1'b1;
        if (sts.sweep_last) state_nxt = S_HASH;
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        if (sts.step_last) state_nxt = S_MOD;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) state_nxt = S_PSTART;
      end
      S_PSTART: begin
        cmd.probe_start = 1'b1;
        state_nxt       = S_SLOT_RD;
      end
      S_SLOT_RD: begin
        cmd.slot_rd = 1'b1;
        state_nxt   = S_SLOT_CHK;
      end
      S_SLOT_CHK: begin
        if (sts.slot_occ) begin
          cmd.ent_rd = 1'b1;
          state_nxt  = S_ENT_CHK;
        end else if (!sts.table_full) begin
          state_nxt = S_INSERT;
        end else if (out_free) begin
          cmd.res_ovf = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_ENT_CHK: begin
        if (sts.key_match) begin
          if (out_free) begin
            cmd.res_match = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else if (sts.probe_last) begin
          if (out_free) begin
            cmd.res_ovf = 1'b1;
            state_nxt   = S_IDLE;
          end
        end else begin
          cmd.probe_next = 1'b1;
          state_nxt      = S_SLOT_RD;
        end
      end
      S_INSERT: begin
        if (out_free) begin
          cmd.insert  = 1'b1;
          cmd.res_new = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_SWEEP_RST;
    endcase
  end

  assign res_any = cmd.res_match || cmd.res_new || cmd.res_ovf;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_any) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  `VDI_ASSERT(a_res_free, clk, rst_n, !res_any || out_free, "result word overwritten while held")
  `VDI_ASSERT(a_res_one, clk, rst_n, $onehot0({cmd.res_match, cmd.res_new, cmd.res_ovf}), "more than one result kind")
  `VDI_ASSERT(a_ins_room, clk, rst_n, !cmd.insert || !sts.table_full, "insert into full vertex store")
  `VDI_ASSERT_NEXT(a_acc_start, clk, rst_n, in_valid && !in_stall, state_r == S_START, "accepted word not started")

endmodule

// ===== hw/rtl/vertex_dedup_indexer.sv =====
// ----------------------------------------------------------------------------
// vertex_dedup_indexer
// one word in flight: the 8-round hash and the 3-step modulo unit run first,
//   then the probe loop reads and checks one slot after another until a match,
//   a free slot or an overflow decides; the result handoff waits on out_stall;
//   a first-of-mesh word on epoch wrap adds a full slot table sweep
// reset: slot table clearing pass over all HASH_SLOTS slots, in_stall high until done
// ----------------------------------------------------------------------------
module vertex_dedup_indexer #(
  parameter int unsigned MAX_VERTICES = 1024,
  parameter int unsigned HASH_SLOTS   = 2048
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  vdi_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output vdi_pkg::out_item_t out_data
);
  import vdi_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: owns the handshakes and the output valid flag, one word in flight;
  // the result register lets the next word enter while a result waits
  vdi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: open addressing with linear probing; slots carry an epoch tag so
  // a new mesh empties the table by bumping the epoch, with a full sweep only
  // when the epoch counter wraps
  vdi_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .HASH_SLOTS   (HASH_SLOTS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// ===== tb/sv/vdi_scoreboard.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vdi_scoreboard
// predicts the index word of each accepted corner and checks the results
// ----------------------------------------------------------------------------
class vdi_scoreboard;

  typedef logic [7:0][31:0] corner_key_t;

  localparam int unsigned VTX_MAX   = 1024;
  localparam int unsigned SLOT_CNT  = 2048;

  corner_key_t             vertex_store [VTX_MAX];
  int unsigned             slot_ref [SLOT_CNT];
  int unsigned             vertex_count;
  vdi_pkg::out_item_t      index_queue [$];
  int unsigned             errors;

  function new();
    foreach (slot_ref[i]) slot_ref[i] = 0;
    vertex_count = 0;
    errors = 0;
  endfunction

  function bit nan_bits(logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 0);
  endfunction

  function bit float_same(logic [31:0] a, logic [31:0] b);
    if (nan_bits(a) || nan_bits(b)) return 0;
    if ((a[30:0] | b[30:0]) == 0) return 1;
    return a == b;
  endfunction

  function int unsigned slot_hash(corner_key_t k);
    logic [31:0] h;
    logic [31:0] w;
    h = 32'h811C_9DC5;
    for (int i = 0; i < 8; i++) begin
      w = k[7-i];
      if (w[30:0] == 0) w = 0;
      h = h ^ w;
      h = h * 32'h0100_0193;
      h = h ^ (h >> 15);
    end
    return h % SLOT_CNT;
  endfunction

  // note an accepted corner and queue its expected index word
  function void note_input(vdi_pkg::in_item_t c);
    corner_key_t        k;
    vdi_pkg::out_item_t r;
    int unsigned        h, s, e, free_slot;
    bit                 found_free, hit;
    if (c.first_of_mesh) begin
      foreach (slot_ref[i]) slot_ref[i] = 0;
      vertex_count = 0;
    end
    // component 0 sits in the top word
    k[7] = c.position_x;
    k[6] = c.position_y;
    k[5] = c.position_z;
    k[4] = c.has_normal ? c.normal_x : 32'h0;
    k[3] = c.has_normal ? c.normal_y : 32'h0;
    k[2] = c.has_normal ? c.normal_z : 32'h3F80_0000;
    k[1] = c.has_texcoord ? c.tex_u : 32'h0;
    k[0] = c.has_texcoord ? c.tex_v : 32'h0;
    h = slot_hash(k);
    found_free = 0;
    hit = 0;
    free_slot = 0;
    r = '0;
    for (int i = 0; i < SLOT_CNT; i++) begin
      s = (h + i) % SLOT_CNT;
      e = slot_ref[s];
      if (e == 0) begin
        found_free = 1;
        free_slot = s;
        break;
      end
      if (e - 1 < VTX_MAX) begin
        hit = 1;
        for (int j = 0; j < 8; j++)
          if (!float_same(vertex_store[e-1][j], k[j])) hit = 0;
        if (hit) begin
          r.vtx_idx = 10'(e - 1);
          break;
        end
      end
    end
    if (!hit) begin
      if (!found_free || vertex_count >= VTX_MAX) begin
        r.overflow = 1;
      end else begin
        vertex_store[vertex_count] = k;
        slot_ref[free_slot] = vertex_count + 1;
        r.vtx_idx = 10'(vertex_count);
        r.is_new = 1;
        vertex_count++;
      end
    end
    index_queue.insert(index_queue.size(), r);
  endfunction

  task report(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  task check_result(vdi_pkg::out_item_t r);
    vdi_pkg::out_item_t w;
    if (index_queue.size() == 0) begin
      report("unexpected word", 16'(r), 16'd0);
      return;
    end
    w = index_queue.pop_front();
    if (r.vtx_idx !== w.vtx_idx) report("vtx_idx", 16'(r.vtx_idx), 16'(w.vtx_idx));
    if (r.is_new !== w.is_new) report("is_new", 16'(r.is_new), 16'(w.is_new));
    if (r.overflow !== w.overflow) report("overflow", 16'(r.overflow), 16'(w.overflow));
  endtask

endclass

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives mesh corners into the vertex dedup indexer under varying idle and
// stall pressure and checks each index word against a predictor
// ----------------------------------------------------------------------------
module testbench;
  import vdi_pkg::*;

  localparam int unsigned QUIET_LIMIT = 60000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  vdi_scoreboard dedup_sb = new();

  int unsigned send_idle_pct;   // chance per cycle that the sender sits idle
  int unsigned recv_stall_pct;  // chance per cycle that the receiver stalls
  int unsigned quiet_cycles;

  // small pool of vertices per mesh so that corners repeat
  in_item_t    mesh_pool [16];

  vertex_dedup_indexer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // receiver side: check words, randomize stall, watch for a hang
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) dedup_sb.check_result(out_data);
    if ((rst_n && out_valid && !out_stall) || (in_valid && !in_stall) || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  function automatic in_item_t mk(bit f, logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                  bit hn, logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                                  bit ht, logic [31:0] u, logic [31:0] v);
    in_item_t c;
    c = {f, px, py, pz, hn, nx, ny, nz, ht, u, v};
    return c;
  endfunction

  // mostly special float codes, the rest arbitrary bits
  function automatic logic [31:0] pick_comp();
    case ($urandom_range(0, 6))
      0: return 32'h0;
      1: return 32'h8000_0000;
      2: return ONE_F;
      3: return 32'h7FC0_0000 | $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  // hold the word until it is taken; valid stays up between back-to-back words
  task send_corner(in_item_t c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= c;
    do @(posedge clk); while (in_stall);
    dedup_sb.note_input(c);
  endtask

  task fill_pool();
    foreach (mesh_pool[i])
      mesh_pool[i] = mk(0, pick_comp(), pick_comp(), pick_comp(),
                        1'($urandom_range(0, 1)), pick_comp(), pick_comp(), pick_comp(),
                        1'($urandom_range(0, 1)), pick_comp(), pick_comp());
  endtask

  task random_mesh(int unsigned n);
    in_item_t c;
    fill_pool();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        c = mk(0, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)), $urandom,
               $urandom, $urandom, 1'($urandom_range(0, 1)), $urandom, $urandom);
      end else begin
        c = mesh_pool[4'($urandom_range(0, 15))];
        // ignored fields carry noise, zeros may flip sign
        if (!c.has_normal) {c.normal_x, c.normal_y, c.normal_z} = {$urandom, $urandom, $urandom};
        if (!c.has_texcoord) {c.tex_u, c.tex_v} = {$urandom, $urandom};
        if (c.position_x[30:0] == 0 && $urandom_range(0, 1)) c.position_x[31] = ~c.position_x[31];
        if (c.position_y[30:0] == 0 && $urandom_range(0, 1)) c.position_y[31] = ~c.position_y[31];
      end
      c.first_of_mesh = (i == 0);
      send_corner(c);
    end
  endtask

  initial begin
    in_valid = 0;
    in_data = '0;
    rst_n = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;

    // directed corners
    send_corner(mk(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_corner(mk(0, 32'h8000_0000, 0, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0));
    send_corner(mk(0, 0, 0, 0, 1, 0, 32'h8000_0000, ONE_F, 1, 32'h8000_0000, 0));
    send_corner(mk(0, 0, 0, 0, 1, 0, 0, 32'hBF80_0000, 0, 0, 0));
    send_corner(mk(0, 32'h7FC0_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_corner(mk(0, 32'h7FC0_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_corner(mk(1'b1, '1, '1, '1, 1, '1, '1, '1, 1, '1, '1));
    send_corner(mk(0, '1, '1, '1, 1, '1, '1, '1, 1, '1, '1));
    send_corner(mk(0, 32'h7F80_0000, 32'hFF80_0000, 32'h7F80_0000, 1, 32'h7F7F_FFFF,
                   32'h0000_0001, 32'h8000_0001, 1, 32'h7F80_0000, ONE_F));
    send_corner(mk(0, 32'h7F80_0000, 32'hFF80_0000, 32'h7F80_0000, 1, 32'h7F7F_FFFF,
                   32'h0000_0001, 32'h8000_0001, 1, 32'h7F80_0000, ONE_F));
    send_corner(mk(0, ONE_F, 0, 0, 0, '1, '1, '1, 0, '1, '1));
    send_corner(mk(0, ONE_F, 0, 0, 1, 32'h8000_0000, 0, ONE_F, 1, 0, 32'h8000_0000));
    send_corner(mk(0, ONE_F, 0, 0, 0, 0, 0, 0, 1, 32'h3F00_0000, 0));
    send_corner(mk(0, ONE_F, 0, 0, 0, 0, 0, 0, 1, 32'h3F00_0000, 0));
    send_corner(mk(1, ONE_F, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_corner(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));

    // one mesh that runs past the vertex store size: overflow, then a nan and a zero corner
    for (int i = 0; i < 1030; i++)
      send_corner(mk(i == 0, i, $urandom, ONE_F, 0, 0, 0, 0, 0, 0, 0));
    send_corner(mk(0, 32'h7FC0_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_corner(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      for (int m = 0; m < 6; m++) random_mesh($urandom_range(8, 48));
    end
    in_valid <= 0;

    while (dedup_sb.index_queue.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (dedup_sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/vdi_pkg.sv
hw/rtl/vdi_datapath.sv
hw/rtl/vdi_ctrl.sv
hw/rtl/vertex_dedup_indexer.sv
tb/sv/vdi_scoreboard.sv
tb/sv/testbench.sv
